// ===== design/open_address_hash_table_macros.svh =====
// Assertion macros for the open address hash table.
`ifndef OPEN_ADDRESS_HASH_TABLE_MACROS_SVH
`define OPEN_ADDRESS_HASH_TABLE_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define OAHT_ASSERT_IMPL(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// Next-cycle implication checked outside reset.
`define OAHT_ASSERT_NEXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

// ===== design/oaht_pkg.sv =====
// Package: types, constants and hash constants for the open address hash table.
package oaht_pkg;
  localparam int TableSize = 1024;
  localparam int IdxW = $clog2(TableSize);
  localparam int CntW = IdxW + 1;
  localparam int QDepth = 2;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_FIND   = 2'd1,
    OP_ERASE  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    RS_INSERTED = 3'd0,
    RS_UPDATED  = 3'd1,
    RS_FOUND    = 3'd2,
    RS_NOTFOUND = 3'd3,
    RS_ERASED   = 3'd4,
    RS_FULL     = 3'd5,
    RS_CLEARED  = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    BK_EMPTY = 2'd0,
    BK_OCC   = 2'd1,
    BK_TOMB  = 2'd2
  } bucket_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_H1, S_H2, S_H3, S_H3C, S_H4, S_H5, S_H5C, S_H6,
    S_RD, S_WAIT, S_EVAL, S_WR, S_CLR, S_OUT
  } state_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] key;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic [2:0]      status;
    logic [31:0]     value_out;
    logic [CntW-1:0] occupied_count;
  } rsp_t;

  localparam logic [63:0] HashAdd = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] HashMul1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] HashMul2 = 64'h94d049bb133111eb;
endpackage

// ===== design/oaht_if.sv =====
// Valid/ready channel interface carrying one transaction payload.
interface oaht_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== design/oaht_ram.sv =====
// Generic single-port RAM with registered read.
module oaht_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== design/oaht_front.sv =====
// Front end: accepts request transactions into a short queue.
module oaht_front
  import oaht_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  oaht_if.sink      req,
  input  logic      pop,
  output logic      q_valid,
  output req_t      q_head
);
  localparam int PtrW = $clog2(QDepth);
  localparam logic [PtrW:0] CntFull = (PtrW + 1)'(QDepth);
  req_t            q [QDepth];
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW:0]   fill;
  logic            push;

  assign req.ready = (fill != CntFull);
  assign push = req.valid && req.ready;
  assign q_valid = (fill != '0);
  assign q_head = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= req.payload;
    end
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && q_valid) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill + (PtrW + 1)'(push) - (PtrW + 1)'(pop && q_valid);
    end
  end
endmodule

// ===== design/oaht_back.sv =====
// Back end: hashes the key, walks the probe sequence and updates the table.
`include "open_address_hash_table_macros.svh"
module oaht_back
  import oaht_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  req_t q_head,
  output logic pop,
  oaht_if.source rsp
);
  state_t state;
  state_t state_next;
  req_t   cur;
  logic [63:0] h;
  logic [63:0] mul_k;
  logic [63:0] prod_lo;
  logic [31:0] prod_x;
  logic [31:0] prod_y;
  logic [IdxW-1:0] home;
  logic [IdxW:0]   step;
  logic [IdxW-1:0] slot;
  logic [IdxW-1:0] tri_off;
  logic [IdxW-1:0] clr_idx;
  logic            have_tomb;
  logic [IdxW-1:0] tomb;
  logic [CntW-1:0] occ;
  rsp_t            res;
  logic            res_valid;

  logic            st_we;
  logic [IdxW-1:0] st_addr;
  logic [1:0]      st_wdata;
  logic [1:0]      st_rdata;
  logic            kv_we;
  logic [63:0]     kv_wdata;
  logic [63:0]     kv_rdata;

  oaht_ram #(.Width(2), .Depth(TableSize)) u_state (
    .clk(clk), .we(st_we), .addr(st_addr), .wdata(st_wdata), .rdata(st_rdata));
  oaht_ram #(.Width(64), .Depth(TableSize)) u_kv (
    .clk(clk), .we(kv_we), .addr(st_addr), .wdata(kv_wdata), .rdata(kv_rdata));

  logic is_empty, is_tomb, hit, last;
  assign is_empty = (st_rdata == BK_EMPTY) || (st_rdata == 2'd3);
  assign is_tomb = (st_rdata == BK_TOMB);
  assign hit = (st_rdata == BK_OCC) && (kv_rdata[63:32] == cur.key);
  assign last = (step == (IdxW + 1)'(TableSize - 1));

  // 64-bit multiply as 32-bit partial products, combined the next cycle
  assign mul_k = (state == S_H5) ? HashMul2 : HashMul1;

  // slot(i+1) = slot(i) + 2(i+1); tri_off tracks i + i*i
  always_comb begin
    st_addr = slot;
    if (state == S_CLR || state == S_INIT) begin
      st_addr = clr_idx;
    end else if (state == S_WR) begin
      st_addr = (cur.op == OP_INSERT && !hit && have_tomb) ? tomb : slot;
    end
  end

  always_comb begin
    st_we = 1'b0;
    st_wdata = BK_EMPTY;
    kv_we = 1'b0;
    kv_wdata = {cur.key, cur.value};
    case (state)
      S_INIT, S_CLR: begin
        st_we = 1'b1;
      end
      S_WR: begin
        case (cur.op)
          OP_ERASE: begin
            st_we = 1'b1;
            st_wdata = BK_TOMB;
          end
          default: begin
            st_we = 1'b1;
            st_wdata = BK_OCC;
            kv_we = 1'b1;
          end
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_INIT: if (clr_idx == IdxW'(TableSize - 1)) state_next = S_IDLE;
      S_IDLE: if (q_valid && !res_valid) state_next =
                 (q_head.op == OP_CLEAR) ? S_CLR : S_H1;
      S_H1: state_next = S_H2;
      S_H2: state_next = S_H3;
      S_H3: state_next = S_H3C;
      S_H3C: state_next = S_H4;
      S_H4: state_next = S_H5;
      S_H5: state_next = S_H5C;
      S_H5C: state_next = S_H6;
      S_H6: state_next = S_RD;
      S_RD: state_next = S_WAIT;
      S_WAIT: state_next = S_EVAL;
      S_EVAL: begin
        if (hit) begin
          state_next = (cur.op == OP_FIND) ? S_OUT : S_WR;
        end else if (is_empty) begin
          state_next = (cur.op == OP_INSERT) ? S_WR : S_OUT;
        end else if (last) begin
          state_next = (cur.op == OP_INSERT && (have_tomb || is_tomb)) ? S_WR : S_OUT;
        end else begin
          state_next = S_WAIT;
        end
      end
      S_WR: state_next = S_OUT;
      S_CLR: if (clr_idx == IdxW'(TableSize - 1)) state_next = S_OUT;
      S_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign pop = (state == S_IDLE) && q_valid && !res_valid;
  assign rsp.valid = res_valid;
  assign rsp.payload = res;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_head;
    end
    case (state)
      S_H1: h <= {32'd0, cur.key} + HashAdd;
      S_H2: h <= h ^ (h >> 30);
      S_H3, S_H5: begin
        prod_lo <= 64'(h[31:0]) * 64'(mul_k[31:0]);
        prod_x <= h[31:0] * mul_k[63:32];
        prod_y <= h[63:32] * mul_k[31:0];
      end
      S_H3C, S_H5C: h <= prod_lo + {prod_x + prod_y, 32'd0};
      S_H4: h <= h ^ (h >> 27);
      S_H6: begin
        home <= h[IdxW-1:0] ^ h[IdxW+31-1:31];
        slot <= h[IdxW-1:0] ^ h[IdxW+31-1:31];
        step <= '0;
        tri_off <= '0;
        have_tomb <= 1'b0;
      end
      S_WAIT: ;
      S_EVAL: if (state_next == S_WAIT) begin
        if (is_tomb && !have_tomb) begin
          have_tomb <= 1'b1;
          tomb <= slot;
        end
        step <= step + 1'b1;
        tri_off <= tri_off + {step[IdxW-2:0], 1'b0} + IdxW'(2);
        slot <= home + tri_off + {step[IdxW-2:0], 1'b0} + IdxW'(2);
      end else if (is_tomb && !have_tomb) begin
        have_tomb <= 1'b1;
        tomb <= slot;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      clr_idx <= '0;
      occ <= '0;
      res_valid <= 1'b0;
      res <= '0;
    end else begin
      state <= state_next;
      if (state == S_INIT || state == S_CLR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (rsp.valid && rsp.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_EVAL: begin
          if (hit) begin
            case (cur.op)
              OP_FIND: begin
                res.status <= RS_FOUND;
                res.value_out <= kv_rdata[31:0];
              end
              OP_ERASE: begin
                res.status <= RS_ERASED;
                res.value_out <= '0;
                occ <= occ - 1'b1;
              end
              default: begin
                res.status <= RS_UPDATED;
                res.value_out <= '0;
              end
            endcase
          end else begin
            res.value_out <= '0;
            if (is_empty || last) begin
              if (cur.op == OP_INSERT && (is_empty || have_tomb || is_tomb)) begin
                res.status <= RS_INSERTED;
                occ <= occ + 1'b1;
              end else if (cur.op == OP_INSERT) begin
                res.status <= RS_FULL;
              end else begin
                res.status <= RS_NOTFOUND;
              end
            end
          end
        end
        S_CLR: begin
          occ <= '0;
          res.status <= RS_CLEARED;
          res.value_out <= '0;
        end
        S_OUT: begin
          res.occupied_count <= occ;
          res_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  `OAHT_ASSERT_IMPL(a_occ_range, 1'b1, occ <= CntW'(TableSize), "occupied count overflow")
  `OAHT_ASSERT_IMPL(a_pop_idle, pop, state == S_IDLE && !res_valid, "pop outside idle")
  `OAHT_ASSERT_NEXT(a_out_valid, state == S_OUT, res_valid, "result not posted")
endmodule

// ===== design/open_address_hash_table.sv =====
// Top level of the open address hash table.
//   channel  dir  payload
//   req      in   op, key, value
//   rsp      out  status, value_out, occupied_count
// A dequeued request is hashed (add, xor-shift, multiply, xor-shift, multiply;
// each 64-bit multiply split into 32-bit partial products and a combine; then
// a fold to the home slot), then read, wait, evaluate and output for a
// one-bucket walk. Each further probe step repeats wait and evaluate, and a
// table write adds a write step. Clear and reset sweep the bucket state RAM,
// one bucket a cycle. Requests queue two deep while a result awaits rsp.ready.
module open_address_hash_table
  import oaht_pkg::*;
(
  input logic clk,
  input logic rst,
  oaht_if.sink   req,
  oaht_if.source rsp
);
  logic q_valid;
  logic pop;
  req_t q_head;

  oaht_front u_front (.clk(clk), .rst(rst), .req(req), .pop(pop),
    .q_valid(q_valid), .q_head(q_head));
  oaht_back u_back (.clk(clk), .rst(rst), .q_valid(q_valid), .q_head(q_head),
    .pop(pop), .rsp(rsp));
endmodule
